>>> rtl/core/ille_pkg.sv
// shared types, codes and default sizes for the indexed linked list engine
// no dependencies; imported by the engine and its checker
package ille_pkg;

  localparam int CAPACITY_DEF   = 256;
  localparam int VALUE_BITS_DEF = 16;

  localparam int ACT_BITS    = 3;
  localparam int POS_BITS    = 16;
  localparam int HOP_BITS    = POS_BITS - 1;
  localparam int DATA_BITS   = 16;
  localparam int STATUS_BITS = 2;
  localparam int COUNT_BITS  = 9;

  // request action codes
  localparam logic [ACT_BITS-1:0] ACT_READ = 3'd0;
  localparam logic [ACT_BITS-1:0] ACT_HEAD = 3'd1;
  localparam logic [ACT_BITS-1:0] ACT_TAIL = 3'd2;
  localparam logic [ACT_BITS-1:0] ACT_AT   = 3'd3;
  localparam logic [ACT_BITS-1:0] ACT_DEL  = 3'd4;

  typedef enum logic [STATUS_BITS-1:0] {
    ST_OK   = 2'd0,
    ST_IDX  = 2'd1,
    ST_FULL = 2'd2
  } ille_status_t;

  typedef enum logic [2:0] {
    OP_READ,
    OP_HEAD,
    OP_TAIL,
    OP_MID,
    OP_DEL
  } ille_op_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_CHECK,
    S_ALLOC,
    S_WALK_GO,
    S_WALK,
    S_POST,
    S_RD_DATA,
    S_INS_LINK,
    S_INS_FIX,
    S_DEL_HEAD,
    S_DEL_VICTIM,
    S_DEL_UNLINK,
    S_DONE
  } ille_state_t;

  typedef struct packed {
    logic [ACT_BITS-1:0]        action;
    logic signed [POS_BITS-1:0] position;
    logic [DATA_BITS-1:0]       item_value;
  } ille_in_t;

  typedef struct packed {
    logic [DATA_BITS-1:0]   read_value;
    logic [STATUS_BITS-1:0] status;
    logic [COUNT_BITS-1:0]  count;
  } ille_out_t;

endpackage

>>> rtl/core/ille_ram.sv
// generic simple dual-port ram: one write port, one read port, registered read
// no dependencies
module ille_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_r <= mem[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

>>> rtl/core/indexed_linked_list_engine.sv
// indexed singly linked list engine: slot store, link store and recycle stack
// depends on ille_pkg and ille_ram
//
//   channel  direction  payload      handshake
//   in_      request    ille_in_t    in_valid / in_stall
//   out_     result     ille_out_t   out_valid / out_stall
//
// one request at a time, from acceptance to the next: head and tail inserts pass
// S_CHECK, S_ALLOC, S_DONE; a delete at index zero S_CHECK, S_DEL_HEAD, S_DONE; a
// refused or out of range request S_CHECK, S_DONE; a read at index k follows k
// links, a delete at or insert before index k follows k - 1. the walk follows one
// link per cycle through the link ram read port, up to CAPACITY - 1 links. reset
// clears the control state only, no clearing pass is needed. a result waiting
// under out_stall holds the next request only in S_DONE, after its walk is done.
module indexed_linked_list_engine
  import ille_pkg::*;
#(
  parameter int CAPACITY   = CAPACITY_DEF,
  parameter int VALUE_BITS = VALUE_BITS_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  ille_in_t  in_req,
  output logic      out_valid,
  input  logic      out_stall,
  output ille_out_t out_rsp
);

  localparam int SW   = $clog2(CAPACITY);
  localparam int CW   = $clog2(CAPACITY + 1);
  localparam int CMPW = (CW > POS_BITS) ? CW : POS_BITS;
  localparam logic [CW-1:0] CAP_CNT = CW'(CAPACITY);

  ille_state_t  state_r, state_nxt;
  ille_op_t     op_r, op_nxt;
  ille_in_t     req_r, req_nxt;
  ille_status_t st_r, st_nxt;
  ille_out_t    out_rsp_r, out_rsp_nxt;
  logic         out_valid_r, out_valid_nxt;

  logic [SW-1:0]        head_r, head_nxt;
  logic [SW-1:0]        tail_r, tail_nxt;
  logic [SW-1:0]        cur_r, cur_nxt;
  logic [SW-1:0]        new_r, new_nxt;
  logic [CW-1:0]        count_r, count_nxt;
  logic [CW-1:0]        fresh_r, fresh_nxt;
  logic [CW-1:0]        rec_r, rec_nxt;
  logic [HOP_BITS-1:0]  hops_r, hops_nxt;
  logic [DATA_BITS-1:0] rv_r, rv_nxt;

  // ram ports
  logic                  val_we;
  logic [SW-1:0]         val_waddr, val_raddr;
  logic [VALUE_BITS-1:0] val_wdata, val_rdata;
  logic                  link_we;
  logic [SW-1:0]         link_waddr, link_raddr, link_wdata, link_rdata;
  logic                  stk_we;
  logic [SW-1:0]         stk_waddr, stk_raddr, stk_wdata, stk_rdata;

  // request decode
  logic                pos_neg, idx_in, idx_beyond, idx_zero, idx_end, full;
  logic [HOP_BITS-1:0] pos_hop, pos_hop_m1;
  logic [CMPW-1:0]     pos_c, cnt_c;
  logic [CW-1:0]       rec_m1;
  logic [SW-1:0]       new_slot;
  ille_op_t            chk_op;
  ille_status_t        chk_st;
  logic                chk_fail;

  assign pos_neg    = req_r.position[POS_BITS-1];
  assign pos_hop    = req_r.position[HOP_BITS-1:0];
  assign pos_hop_m1 = pos_hop - HOP_BITS'(1);
  assign pos_c      = CMPW'(pos_hop);
  assign cnt_c      = CMPW'(count_r);
  assign idx_in     = !pos_neg && (pos_c < cnt_c);
  assign idx_beyond = !pos_neg && (pos_c > cnt_c);
  assign idx_zero   = pos_c == '0;
  assign idx_end    = !pos_neg && (pos_c == cnt_c);
  assign full       = count_r == CAP_CNT;
  assign rec_m1     = rec_r - CW'(1);
  // recycled slots first, then slots never used since reset
  assign new_slot   = (rec_r != '0) ? stk_rdata : fresh_r[SW-1:0];

  always_comb begin
    chk_op   = OP_READ;
    chk_st   = ST_OK;
    chk_fail = 1'b0;
    unique case (req_r.action)
      ACT_READ: begin
        chk_op = OP_READ;
        if (!idx_in) begin
          chk_fail = 1'b1;
          chk_st   = ST_IDX;
        end
      end
      ACT_HEAD: begin
        chk_op = OP_HEAD;
        if (full) begin
          chk_fail = 1'b1;
          chk_st   = ST_FULL;
        end
      end
      ACT_TAIL: begin
        chk_op = OP_TAIL;
        if (full) begin
          chk_fail = 1'b1;
          chk_st   = ST_FULL;
        end
      end
      ACT_AT: begin
        priority if (idx_beyond) begin
          chk_fail = 1'b1;
          chk_st   = ST_IDX;
        end else if (full) begin
          chk_fail = 1'b1;
          chk_st   = ST_FULL;
        end else if (pos_neg || idx_zero) begin
          chk_op = OP_HEAD;
        end else if (idx_end) begin
          chk_op = OP_TAIL;
        end else begin
          chk_op = OP_MID;
        end
      end
      ACT_DEL: begin
        chk_op = OP_DEL;
        if (!idx_in) begin
          chk_fail = 1'b1;
          chk_st   = ST_IDX;
        end
      end
      default: begin
        chk_fail = 1'b1;
        chk_st   = ST_IDX;
      end
    endcase
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) state_nxt = S_CHECK;
      end
      S_CHECK: begin
        if (chk_fail) begin
          state_nxt = S_DONE;
        end else begin
          unique case (chk_op)
            OP_READ: state_nxt = S_WALK_GO;
            OP_DEL:  state_nxt = idx_zero ? S_DEL_HEAD : S_WALK_GO;
            default: state_nxt = S_ALLOC;
          endcase
        end
      end
      S_ALLOC:      state_nxt = (op_r == OP_MID) ? S_WALK_GO : S_DONE;
      S_WALK_GO:    state_nxt = (hops_r == '0) ? S_POST : S_WALK;
      S_WALK:       state_nxt = (hops_r == HOP_BITS'(1)) ? S_POST : S_WALK;
      S_POST: begin
        unique case (op_r)
          OP_READ: state_nxt = S_RD_DATA;
          OP_MID:  state_nxt = S_INS_LINK;
          default: state_nxt = S_DEL_VICTIM;
        endcase
      end
      S_RD_DATA:    state_nxt = S_DONE;
      S_INS_LINK:   state_nxt = S_INS_FIX;
      S_INS_FIX:    state_nxt = S_DONE;
      S_DEL_HEAD:   state_nxt = S_DONE;
      S_DEL_VICTIM: state_nxt = S_DEL_UNLINK;
      S_DEL_UNLINK: state_nxt = S_DONE;
      S_DONE: begin
        if (!out_valid_r || !out_stall) state_nxt = S_IDLE;
      end
      default:      state_nxt = S_IDLE;
    endcase
  end

  // datapath and ram control
  always_comb begin
    req_nxt   = req_r;
    op_nxt    = op_r;
    st_nxt    = st_r;
    rv_nxt    = rv_r;
    head_nxt  = head_r;
    tail_nxt  = tail_r;
    cur_nxt   = cur_r;
    new_nxt   = new_r;
    count_nxt = count_r;
    fresh_nxt = fresh_r;
    rec_nxt   = rec_r;
    hops_nxt  = hops_r;

    val_we     = 1'b0;
    val_waddr  = new_slot;
    val_wdata  = VALUE_BITS'(req_r.item_value);
    val_raddr  = cur_r;
    link_we    = 1'b0;
    link_waddr = cur_r;
    link_wdata = new_r;
    link_raddr = cur_r;
    stk_we     = 1'b0;
    stk_waddr  = rec_r[SW-1:0];
    stk_wdata  = link_rdata;
    stk_raddr  = rec_m1[SW-1:0];

    out_valid_nxt = out_valid_r && out_stall;
    out_rsp_nxt   = out_rsp_r;

    unique case (state_r)
      S_IDLE: begin
        if (in_valid) req_nxt = in_req;
      end
      S_CHECK: begin
        op_nxt     = chk_op;
        st_nxt     = chk_st;
        rv_nxt     = '0;
        cur_nxt    = head_r;
        hops_nxt   = (chk_op == OP_READ) ? pos_hop : pos_hop_m1;
        link_raddr = head_r;
      end
      S_ALLOC: begin
        val_we  = 1'b1;
        new_nxt = new_slot;
        if (rec_r != '0) rec_nxt = rec_m1;
        else fresh_nxt = fresh_r + CW'(1);
        unique case (op_r)
          OP_HEAD: begin
            link_we    = 1'b1;
            link_waddr = new_slot;
            link_wdata = head_r;
            head_nxt   = new_slot;
            if (count_r == '0) tail_nxt = new_slot;
            count_nxt  = count_r + CW'(1);
          end
          OP_TAIL: begin
            if (count_r == '0) begin
              head_nxt = new_slot;
            end else begin
              link_we    = 1'b1;
              link_waddr = tail_r;
              link_wdata = new_slot;
            end
            tail_nxt  = new_slot;
            count_nxt = count_r + CW'(1);
          end
          default: ;
        endcase
      end
      S_WALK_GO: ;
      S_WALK: begin
        // one hop per cycle: the fetched link is the next read address
        if (hops_r == HOP_BITS'(1)) begin
          cur_nxt = link_rdata;
        end else begin
          hops_nxt   = hops_r - HOP_BITS'(1);
          link_raddr = link_rdata;
        end
      end
      S_POST: ;
      S_RD_DATA: begin
        rv_nxt = DATA_BITS'(val_rdata);
      end
      S_INS_LINK: begin
        link_we    = 1'b1;
        link_waddr = new_r;
        link_wdata = link_rdata;
      end
      S_INS_FIX: begin
        link_we    = 1'b1;
        link_waddr = cur_r;
        link_wdata = new_r;
        count_nxt  = count_r + CW'(1);
      end
      S_DEL_HEAD: begin
        head_nxt  = link_rdata;
        stk_we    = 1'b1;
        stk_wdata = head_r;
        rec_nxt   = rec_r + CW'(1);
        count_nxt = count_r - CW'(1);
      end
      S_DEL_VICTIM: begin
        // link_rdata is the victim slot, fetch its successor
        stk_we     = 1'b1;
        stk_wdata  = link_rdata;
        rec_nxt    = rec_r + CW'(1);
        count_nxt  = count_r - CW'(1);
        link_raddr = link_rdata;
        if (link_rdata == tail_r) tail_nxt = cur_r;
      end
      S_DEL_UNLINK: begin
        link_we    = 1'b1;
        link_waddr = cur_r;
        link_wdata = link_rdata;
      end
      S_DONE: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt          = 1'b1;
          out_rsp_nxt.read_value = rv_r;
          out_rsp_nxt.status     = st_r;
          out_rsp_nxt.count      = COUNT_BITS'(count_r);
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      head_r      <= '0;
      tail_r      <= '0;
      count_r     <= '0;
      fresh_r     <= '0;
      rec_r       <= '0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      head_r      <= head_nxt;
      tail_r      <= tail_nxt;
      count_r     <= count_nxt;
      fresh_r     <= fresh_nxt;
      rec_r       <= rec_nxt;
    end
  end

  always_ff @(posedge clk) begin
    req_r     <= req_nxt;
    op_r      <= op_nxt;
    st_r      <= st_nxt;
    rv_r      <= rv_nxt;
    cur_r     <= cur_nxt;
    new_r     <= new_nxt;
    hops_r    <= hops_nxt;
    out_rsp_r <= out_rsp_nxt;
  end

  ille_ram #(
    .WIDTH(VALUE_BITS),
    .DEPTH(CAPACITY)
  ) u_value_ram (
    .clk    (clk),
    .wr_en  (val_we),
    .wr_addr(val_waddr),
    .wr_data(val_wdata),
    .rd_addr(val_raddr),
    .rd_data(val_rdata)
  );

  ille_ram #(
    .WIDTH(SW),
    .DEPTH(CAPACITY)
  ) u_link_ram (
    .clk    (clk),
    .wr_en  (link_we),
    .wr_addr(link_waddr),
    .wr_data(link_wdata),
    .rd_addr(link_raddr),
    .rd_data(link_rdata)
  );

  ille_ram #(
    .WIDTH(SW),
    .DEPTH(CAPACITY)
  ) u_stack_ram (
    .clk    (clk),
    .wr_en  (stk_we),
    .wr_addr(stk_waddr),
    .wr_data(stk_wdata),
    .rd_addr(stk_raddr),
    .rd_data(stk_rdata)
  );

  assign in_stall  = state_r != S_IDLE;
  assign out_valid = out_valid_r;
  assign out_rsp   = out_rsp_r;

endmodule

>>> rtl/core/ille_checker.sv
// port-level checks for the indexed linked list engine, bound to the top level
// depends on ille_pkg and indexed_linked_list_engine
module ille_checker
  import ille_pkg::*;
#(
  parameter int CAPACITY = CAPACITY_DEF
) (
  input logic      clk,
  input logic      rst_n,
  input logic      in_valid,
  input logic      in_stall,
  input logic      out_valid,
  input logic      out_stall,
  input ille_out_t out_rsp
);

  // a request keeps the engine busy for at least the next cycle
  a_busy_after_request: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("engine ready right after taking a request");

  a_value_only_on_success: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_rsp.status != ST_OK) |-> out_rsp.read_value == '0)
    else $error("nonzero read value on a failed request");

  a_count_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> int'(out_rsp.count) <= CAPACITY)
    else $error("count above capacity");

  a_full_means_capacity: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_rsp.status == ST_FULL) |-> out_rsp.count == COUNT_BITS'(CAPACITY))
    else $error("full status with store not full");

  a_result_holds: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_rsp))
    else $error("stalled result changed or dropped");

endmodule

bind indexed_linked_list_engine ille_checker #(
  .CAPACITY(CAPACITY)
) u_ille_checker (
  .clk      (clk),
  .rst_n    (rst_n),
  .in_valid (in_valid),
  .in_stall (in_stall),
  .out_valid(out_valid),
  .out_stall(out_stall),
  .out_rsp  (out_rsp)
);
